// ===== src/tsel_pkg.sv =====
// Shared types and constants for the TLS server-name extension locator.
`timescale 1ns / 1ps

package tsel_pkg;

    // Default upper bound on the record length in bytes.
    localparam int MAX_RECORD_BYTES_DEF = 65536;

    // Field positions wrap at this width, as the length sums may exceed the record.
    localparam int FIELD_POS_W = 18;

    localparam int OFFSET_W  = 16;
    localparam int LENGTH_W  = 17;
    localparam int IN_DATA_W = 8;
    // status, offset and length packed from bit 0, padded to whole bytes.
    localparam int OUT_DATA_W = 40;

    localparam logic [7:0]  HANDSHAKE_TYPE  = 8'h16;
    localparam logic [15:0] SERVER_NAME_EXT = 16'h0000;
    localparam int          HEADER_LAST_POS = 42;
    localparam int          HEADER_BYTES    = 43;
    localparam int          SID_BASE        = 44;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_SHORT = 2'd1,
        ST_TRUNC = 2'd2,
        ST_NONE  = 2'd3
    } t_status;

    typedef struct packed {
        logic                 last_byte;
        logic [IN_DATA_W-1:0] data_byte;
    } t_item;

    typedef struct packed {
        logic [LENGTH_W-1:0] ext_length;
        logic [OFFSET_W-1:0] ext_offset;
        t_status             status;
    } t_result;

endpackage

// ===== src/tsel_in_stage.sv =====
// Input register stage holding one request ahead of the parser.
`timescale 1ns / 1ps

module tsel_in_stage
    import tsel_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [IN_DATA_W-1:0] i_s_axis_tdata,
    input  logic                 i_s_axis_tlast,
    input  logic                 i_take,
    output logic                 o_valid,
    output t_item                o_item
);

    logic  r_valid;
    t_item r_item;

    // The register refills in the same cycle that the parser drains it.
    assign o_s_axis_tready = !r_valid || i_take;
    assign o_valid         = r_valid;
    assign o_item          = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_item.data_byte <= i_s_axis_tdata;
            r_item.last_byte <= i_s_axis_tlast;
        end
    end

endmodule

// ===== src/tsel_parser.sv =====
// ClientHello field walker: tracks the position and forms the verdict on the last byte.
`timescale 1ns / 1ps

module tsel_parser
    import tsel_pkg::*;
#(
    parameter int MAX_RECORD_BYTES = MAX_RECORD_BYTES_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_item   i_item,
    input  logic    i_out_ready,
    output logic    o_take,
    output logic    o_res_valid,
    output t_result o_result
);

    localparam int POS_W = $clog2(MAX_RECORD_BYTES + 1);
    localparam logic [POS_W-1:0] MaxPos = POS_W'(MAX_RECORD_BYTES);
    localparam logic [POS_W-1:0] HdrLast = POS_W'(HEADER_LAST_POS);
    localparam logic [FIELD_POS_W-1:0] FieldStart = FIELD_POS_W'(HEADER_BYTES);

    typedef enum logic [3:0] {
        PH_HDR     = 4'd0,
        PH_SID     = 4'd1,
        PH_CS_HI   = 4'd2,
        PH_CS_LO   = 4'd3,
        PH_CM      = 4'd4,
        PH_EL_HI   = 4'd5,
        PH_EL_LO   = 4'd6,
        PH_T_HI    = 4'd7,
        PH_T_LO    = 4'd8,
        PH_SNI_HI  = 4'd9,
        PH_SNI_LO  = 4'd10,
        PH_SKIP_HI = 4'd11,
        PH_SKIP_LO = 4'd12,
        PH_DONE    = 4'd13
    } t_phase;

    logic [POS_W-1:0]       r_pos, n_pos;
    t_phase                 r_phase, n_phase;
    logic [7:0]             r_acc_hi, n_acc_hi;
    logic [FIELD_POS_W-1:0] r_next, n_next;
    logic [FIELD_POS_W-1:0] r_list_end, n_list_end;
    logic [OFFSET_W-1:0]    r_found_off, n_found_off;
    logic [LENGTH_W-1:0]    r_found_len, n_found_len;
    logic                   r_found, n_found;
    t_status                r_err, n_err;

    logic [7:0]             b;
    logic [15:0]            field;
    logic                   at_next;
    logic [FIELD_POS_W-1:0] pos_ext;
    t_status                verdict;

    // Only the closing byte needs room in the result register.
    assign o_take      = i_valid && (i_out_ready || !i_item.last_byte);
    assign o_res_valid = o_take && i_item.last_byte;

    assign b       = i_item.data_byte;
    assign field   = {r_acc_hi, b};
    assign pos_ext = FIELD_POS_W'(r_pos);
    assign at_next = (pos_ext == r_next);

    // Decide whether another extension header of four bytes fits before the list end.
    function automatic t_phase walk_phase(input logic [FIELD_POS_W-1:0] nf,
                                          input logic [FIELD_POS_W-1:0] le);
        if ((FIELD_POS_W + 1)'(nf) + (FIELD_POS_W + 1)'(4) <= (FIELD_POS_W + 1)'(le)) begin
            return PH_T_HI;
        end
        return PH_DONE;
    endfunction

    always_comb begin
        n_pos       = r_pos;
        n_phase     = r_phase;
        n_acc_hi    = r_acc_hi;
        n_next      = r_next;
        n_list_end  = r_list_end;
        n_found_off = r_found_off;
        n_found_len = r_found_len;
        n_found     = r_found;
        n_err       = r_err;

        if (r_pos == MaxPos) begin
            // Bytes past the maximum length are dropped.
            if (r_err == ST_OK) begin
                n_err = ST_TRUNC;
            end
        end else begin
            n_pos = r_pos + POS_W'(1);
            unique case (r_phase)
                PH_HDR: begin
                    if (r_pos == '0 && b != HANDSHAKE_TYPE && r_err == ST_OK) begin
                        n_err = ST_SHORT;
                    end
                    if (r_pos == HdrLast) begin
                        n_phase = PH_SID;
                    end
                end
                PH_SID: begin
                    n_next  = FIELD_POS_W'(SID_BASE) + FIELD_POS_W'(b);
                    n_phase = PH_CS_HI;
                end
                PH_CS_HI, PH_EL_HI, PH_T_HI: begin
                    if (at_next) begin
                        n_acc_hi = b;
                        n_phase  = t_phase'(r_phase + 4'd1);
                    end
                end
                PH_CS_LO: begin
                    n_next  = r_next + FIELD_POS_W'(2) + FIELD_POS_W'(field);
                    n_phase = PH_CM;
                end
                PH_CM: begin
                    if (at_next) begin
                        n_next  = r_next + FIELD_POS_W'(1) + FIELD_POS_W'(b);
                        n_phase = PH_EL_HI;
                    end
                end
                PH_EL_LO: begin
                    n_next     = r_next + FIELD_POS_W'(2);
                    n_list_end = n_next + FIELD_POS_W'(field);
                    n_phase    = walk_phase(n_next, n_list_end);
                end
                PH_T_LO: begin
                    n_phase = (field == SERVER_NAME_EXT) ? PH_SNI_HI : PH_SKIP_HI;
                end
                PH_SNI_HI, PH_SKIP_HI: begin
                    n_acc_hi = b;
                    n_phase  = t_phase'(r_phase + 4'd1);
                end
                PH_SNI_LO: begin
                    n_found_off = r_next[OFFSET_W-1:0];
                    n_found_len = LENGTH_W'(field) + LENGTH_W'(4);
                    n_found     = 1'b1;
                    n_phase     = PH_DONE;
                end
                PH_SKIP_LO: begin
                    n_next  = r_next + FIELD_POS_W'(4) + FIELD_POS_W'(field);
                    n_phase = walk_phase(n_next, n_list_end);
                end
                PH_DONE: begin
                end
                default: begin
                end
            endcase
        end
    end

    // The verdict sees the fault and find state as updated by the closing byte.
    always_comb begin
        if (n_err != ST_OK) begin
            verdict = n_err;
        end else if (r_pos <= HdrLast) begin
            verdict = ST_SHORT;
        end else if (r_phase <= PH_EL_LO) begin
            verdict = ST_TRUNC;
        end else if (pos_ext + FIELD_POS_W'(1) < n_list_end) begin
            verdict = ST_TRUNC;
        end else begin
            verdict = n_found ? ST_OK : ST_NONE;
        end
        o_result.status     = verdict;
        o_result.ext_offset = (verdict == ST_OK) ? n_found_off : '0;
        o_result.ext_length = (verdict == ST_OK) ? n_found_len : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_res_valid) begin
            r_pos       <= '0;
            r_phase     <= PH_HDR;
            r_acc_hi    <= '0;
            r_next      <= FieldStart;
            r_list_end  <= '0;
            r_found_off <= '0;
            r_found_len <= '0;
            r_found     <= 1'b0;
            r_err       <= ST_OK;
        end else if (o_take) begin
            r_pos       <= n_pos;
            r_phase     <= n_phase;
            r_acc_hi    <= n_acc_hi;
            r_next      <= n_next;
            r_list_end  <= n_list_end;
            r_found_off <= n_found_off;
            r_found_len <= n_found_len;
            r_found     <= n_found;
            r_err       <= n_err;
        end
    end

endmodule

// ===== src/tsel_out_stage.sv =====
// Result register driving the master-side stream.
`timescale 1ns / 1ps

module tsel_out_stage
    import tsel_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_res_valid,
    input  t_result               i_result,
    output logic                  o_ready,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    logic    r_valid;
    t_result r_result;

    assign o_ready         = !r_valid || i_m_axis_tready;
    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = OUT_DATA_W'(r_result);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_res_valid) begin
            r_result <= i_result;
        end
    end

endmodule

// ===== src/tls_sni_extension_locator_unit.sv =====
// Top level of the TLS ClientHello server-name extension locator.
//
// The slave stream carries one byte of a TLS record per request, with tlast on
// the final byte. Non-final bytes produce nothing; the final byte produces a
// single verdict request on the master stream with the status, the offset of
// the server-name extension type field and its length including the header.
// Status 0 means found, 1 short or not a handshake, 2 truncated or too long,
// 3 no server-name extension; offset and length are zero unless found.
// One byte is accepted every cycle unless the slave side is held as described
// below. A byte waits in the input register and is parsed combinationally as it
// leaves it; the verdict is then captured in the result register, from which it
// is presented on the master stream.
// When the receiver stalls, the verdict waits in the result register while
// bytes of the next record keep flowing until another verdict would be due;
// only then is the slave side held.
// Reset clears both stream registers and returns the walker to the start of a
// record. After each verdict the walker restarts for the next record.
`timescale 1ns / 1ps

module tls_sni_extension_locator_unit
    import tsel_pkg::*;
#(
    parameter int MAX_RECORD_BYTES = MAX_RECORD_BYTES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // data_byte in [7:0]
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    input  logic                  i_s_axis_tlast,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // status [1:0], ext_offset [17:2], ext_length [34:18], zero [39:35]
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    logic    in_valid;
    t_item   in_item;
    logic    take;
    logic    out_ready;
    logic    res_valid;
    t_result result;

    tsel_in_stage u_in_stage (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .i_take          (take),
        .o_valid         (in_valid),
        .o_item          (in_item)
    );

    tsel_parser #(
        .MAX_RECORD_BYTES (MAX_RECORD_BYTES)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (in_valid),
        .i_item      (in_item),
        .i_out_ready (out_ready),
        .o_take      (take),
        .o_res_valid (res_valid),
        .o_result    (result)
    );

    tsel_out_stage u_out_stage (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_res_valid     (res_valid),
        .i_result        (result),
        .o_ready         (out_ready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

endmodule
